>>> hw/rtl/pcat_pkg.sv
package pcat_pkg;

  localparam int SLOTS_DEF   = 32;
  localparam int PID_W       = 22;
  localparam int SHARE_SCALE = 10000;
  localparam int LOAD_SCALE  = 255;

  localparam logic [8:0]  CPU_COUNT_RST = 9'd1;
  localparam logic [13:0] TPS_RST       = 14'd100;
  localparam logic [7:0]  EXPIRY_RST    = 8'd10;

  localparam logic [1:0] CFG_CPU_COUNT = 2'd0;
  localparam logic [1:0] CFG_TPS       = 2'd1;
  localparam logic [1:0] CFG_EXPIRY    = 2'd2;

  localparam logic [1:0] ST_UPDATED  = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_DROPPED  = 2'd2;
  localparam logic [1:0] ST_DONE     = 2'd3;

  typedef enum logic [1:0] {
    KIND_REPORT = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_CALC   = 2'd2,
    KIND_ROUND  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    WSEL_UPDATE = 2'd0,
    WSEL_INSERT = 2'd1,
    WSEL_EXPIRE = 2'd2,
    WSEL_REBASE = 2'd3
  } wsel_t;

  typedef enum logic [2:0] {
    OSEL_UPDATE  = 3'd0,
    OSEL_INSERT  = 3'd1,
    OSEL_DROP    = 3'd2,
    OSEL_ENTRY   = 3'd3,
    OSEL_SUMMARY = 3'd4,
    OSEL_DONE    = 3'd5
  } osel_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] now_seconds;
    logic [21:0] proc_id;
    logic [31:0] user_ticks;
    logic [31:0] system_ticks;
    logic [31:0] user_id;
    logic [31:0] group_id;
    logic [15:0] mem_share;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  slot_index;
    logic [21:0] entry_proc_id;
    logic [13:0] cpu_share;
    logic [15:0] entry_mem_share;
    logic [31:0] entry_user_id;
    logic [31:0] entry_group_id;
    logic [7:0]  total_share;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [21:0] pid;
    logic [31:0] user_start;
    logic [31:0] system_start;
    logic [31:0] user_run;
    logic [31:0] system_run;
    logic [31:0] owner_user;
    logic [31:0] owner_group;
    logic [31:0] last_seen;
    logic [15:0] mem;
  } slot_t;

  typedef struct packed {
    logic  latch;
    logic  ram_rd;
    logic  scan_eval;
    logic  place;
    logic  ram_we;
    wsel_t wsel;
    logic  idx_inc;
    logic  ela_calc;
    logic  entry_acc;
    logic  entry_mul;
    logic  sum_lim;
    logic  sum_clamp;
    logic  sum_mul;
    logic  div_start;
    logic  div_by_cpu;
    logic  out_load;
    osel_t osel;
    logic  set_time;
    logic  set_round;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  pid_zero;
    logic  idx_end;
    logic  match;
    logic  free_found;
    logic  full;
    logic  live;
    logic  expired;
    logic  div_done;
    logic  out_valid;
    logic  out_fire;
    logic  out_last;
  } status_t;

endpackage

>>> hw/rtl/pcat_if.sv
interface pcat_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] now_seconds;
  logic [21:0] proc_id;
  logic [31:0] user_ticks;
  logic [31:0] system_ticks;
  logic [31:0] user_id;
  logic [31:0] group_id;
  logic [15:0] mem_share;

  modport source (output valid, kind, now_seconds, proc_id, user_ticks, system_ticks,
                  user_id, group_id, mem_share, input ready);
  modport sink (input valid, kind, now_seconds, proc_id, user_ticks, system_ticks,
                user_id, group_id, mem_share, output ready);
endinterface

interface pcat_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [4:0]  slot_index;
  logic [21:0] entry_proc_id;
  logic [13:0] cpu_share;
  logic [15:0] entry_mem_share;
  logic [31:0] entry_user_id;
  logic [31:0] entry_group_id;
  logic [7:0]  total_share;
  logic        last;

  modport source (output valid, status, slot_index, entry_proc_id, cpu_share,
                  entry_mem_share, entry_user_id, entry_group_id, total_share, last,
                  input ready);
  modport sink (input valid, status, slot_index, entry_proc_id, cpu_share,
                entry_mem_share, entry_user_id, entry_group_id, total_share, last,
                output ready);
endinterface

>>> hw/rtl/process_cpu_accounting_table.sv
// A report reads the table RAM at most once per used slot, stopping at a matching slot.
// Calculate runs the 32-step bit-serial divider once per live slot and twice for the
// summary; a new round reads every used slot once.
// Requests: one at a time; the next is taken once the last result has gone.
// Reset is synchronous; slots_used returns to zero so the table reads as empty and
// its RAM needs no clearing pass.
module process_cpu_accounting_table #(
  parameter int SLOTS = pcat_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  pcat_req_if.sink    request,
  pcat_res_if.source  result,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_wr_data
);
  pcat_pkg::req_t    item_in;
  pcat_pkg::res_t    res;
  pcat_pkg::cmd_t    cmd;
  pcat_pkg::status_t st;
  logic              req_ready;
  logic              out_valid;

  assign item_in.kind         = pcat_pkg::kind_t'(request.kind);
  assign item_in.now_seconds  = request.now_seconds;
  assign item_in.proc_id      = request.proc_id;
  assign item_in.user_ticks   = request.user_ticks;
  assign item_in.system_ticks = request.system_ticks;
  assign item_in.user_id      = request.user_id;
  assign item_in.group_id     = request.group_id;
  assign item_in.mem_share    = request.mem_share;
  assign request.ready        = req_ready;

  assign result.valid           = out_valid;
  assign result.status          = res.status;
  assign result.slot_index      = res.slot_index;
  assign result.entry_proc_id   = res.entry_proc_id;
  assign result.cpu_share       = res.cpu_share;
  assign result.entry_mem_share = res.entry_mem_share;
  assign result.entry_user_id   = res.entry_user_id;
  assign result.entry_group_id  = res.entry_group_id;
  assign result.total_share     = res.total_share;
  assign result.last            = res.last;

  pcat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (req_ready),
    .st        (st),
    .cmd       (cmd)
  );

  pcat_dp #(.SLOTS(SLOTS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .item_in     (item_in),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (out_valid),
    .out_ready   (result.ready),
    .res         (res),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );
endmodule

>>> hw/rtl/pcat_ram.sv
module pcat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> hw/rtl/pcat_div.sv
module pcat_div #(
  parameter int DW = 32,
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic          done
);
  localparam int CNTW = $clog2(DW + 1);

  logic [VW-1:0]   rem;
  logic [VW-1:0]   dvs;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [VW:0]     shifted;
  logic            ge;

  // One quotient bit per cycle, restoring form.
  assign shifted = {rem, quotient[DW-1]};
  assign ge      = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNTW'(DW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNTW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[DW-2:0], ge};
      rem      <= ge ? VW'(shifted - {1'b0, dvs}) : shifted[VW-1:0];
    end
  end
endmodule

>>> hw/rtl/pcat_dp.sv
module pcat_dp #(
  parameter int SLOTS = pcat_pkg::SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  pcat_pkg::req_t    item_in,
  input  pcat_pkg::cmd_t    cmd,
  output pcat_pkg::status_t st,
  output logic              out_valid,
  input  logic              out_ready,
  output pcat_pkg::res_t    res,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [13:0]       cfg_wr_data
);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TW = 16 + $clog2(SLOTS + 1);
  localparam int SW = $bits(pcat_pkg::slot_t);

  pcat_pkg::req_t  item;
  pcat_pkg::slot_t rdata;
  pcat_pkg::slot_t wdata;
  pcat_pkg::res_t  res_next;

  logic [8:0]    cpu_count;
  logic [13:0]   tps;
  logic [7:0]    expiry;
  logic [CW-1:0] used;
  logic [CW-1:0] idx;
  logic [AW-1:0] tgt;
  logic [AW-1:0] free_idx;
  logic          free_f;
  logic [31:0]   cur_time;
  logic [31:0]   round_start;
  logic [15:0]   elapsed;
  logic [15:0]   tick;
  logic [TW-1:0] total;
  logic [24:0]   lim;
  logic [31:0]   prod;

  logic [8:0]    ncpu;
  logic [15:0]   span;
  logic [29:0]   ela_prod;
  logic [32:0]   run_sum;
  logic [29:0]   share_prod;
  logic [31:0]   sum_prod;
  logic [24:0]   lim_prod;
  logic [31:0]   idle_time;
  logic          ram_we;
  logic [AW-1:0] waddr;
  logic [31:0]   dvd;
  logic [15:0]   dvs;
  logic [31:0]   quotient;
  logic          div_done;

  assign ncpu       = (cpu_count == '0) ? 9'd1 : cpu_count;
  assign span       = cur_time[15:0] - round_start[15:0];
  assign ela_prod   = span * tps;
  assign run_sum    = {1'b0, rdata.user_run} + {1'b0, rdata.system_run};
  assign share_prod = 30'(pcat_pkg::SHARE_SCALE) * 30'(tick);
  assign sum_prod   = 32'(pcat_pkg::LOAD_SCALE) * 32'(total);
  assign lim_prod   = elapsed * ncpu;
  assign idle_time  = cur_time - rdata.last_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_count <= pcat_pkg::CPU_COUNT_RST;
      tps       <= pcat_pkg::TPS_RST;
      expiry    <= pcat_pkg::EXPIRY_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pcat_pkg::CFG_CPU_COUNT: cpu_count <= cfg_wr_data[8:0];
        pcat_pkg::CFG_TPS:       tps       <= cfg_wr_data;
        pcat_pkg::CFG_EXPIRY:    expiry    <= cfg_wr_data[7:0];
        default: ;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      used        <= '0;
      idx         <= '0;
      free_f      <= 1'b0;
      cur_time    <= '0;
      round_start <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.latch) begin
        idx    <= '0;
        free_f <= 1'b0;
      end
      if (cmd.scan_eval) begin
        idx <= idx + 1'b1;
        if (rdata.pid == '0 && !free_f) begin
          free_f <= 1'b1;
        end
      end
      if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (cmd.place && !free_f) begin
        used <= used + 1'b1;
      end
      if (cmd.set_time) begin
        cur_time <= item.now_seconds;
      end
      if (cmd.set_round) begin
        round_start <= cur_time;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    res_next = '0;
    case (cmd.osel)
      pcat_pkg::OSEL_UPDATE: begin
        res_next.status          = pcat_pkg::ST_UPDATED;
        res_next.slot_index      = 5'(tgt);
        res_next.entry_proc_id   = item.proc_id;
        res_next.entry_mem_share = item.mem_share;
        res_next.entry_user_id   = rdata.owner_user;
        res_next.entry_group_id  = rdata.owner_group;
        res_next.last            = 1'b1;
      end
      pcat_pkg::OSEL_INSERT: begin
        res_next.status          = pcat_pkg::ST_INSERTED;
        res_next.slot_index      = 5'(tgt);
        res_next.entry_proc_id   = item.proc_id;
        res_next.entry_mem_share = item.mem_share;
        res_next.entry_user_id   = item.user_id;
        res_next.entry_group_id  = item.group_id;
        res_next.last            = 1'b1;
      end
      pcat_pkg::OSEL_DROP: begin
        res_next.status        = pcat_pkg::ST_DROPPED;
        res_next.entry_proc_id = item.proc_id;
        res_next.last          = 1'b1;
      end
      pcat_pkg::OSEL_ENTRY: begin
        res_next.status          = pcat_pkg::ST_DONE;
        res_next.slot_index      = 5'(tgt);
        res_next.entry_proc_id   = rdata.pid;
        res_next.cpu_share       = quotient[13:0];
        res_next.entry_mem_share = rdata.mem;
        res_next.entry_user_id   = rdata.owner_user;
        res_next.entry_group_id  = rdata.owner_group;
      end
      pcat_pkg::OSEL_SUMMARY: begin
        res_next.status      = pcat_pkg::ST_DONE;
        res_next.total_share = quotient[7:0];
        res_next.last        = 1'b1;
      end
      default: begin
        res_next.status = pcat_pkg::ST_DONE;
        res_next.last   = 1'b1;
      end
    endcase
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item <= item_in;
    end
    if (cmd.scan_eval) begin
      if (rdata.pid == item.proc_id) begin
        tgt <= AW'(idx);
      end
      if (rdata.pid == '0 && !free_f) begin
        free_idx <= AW'(idx);
      end
    end
    if (cmd.place) begin
      tgt <= free_f ? free_idx : AW'(used);
    end
    if (cmd.ela_calc) begin
      elapsed <= (ela_prod[15:0] == '0) ? 16'd1 : ela_prod[15:0];
      total   <= '0;
    end
    if (cmd.entry_acc) begin
      tick  <= (run_sum > {17'd0, elapsed}) ? elapsed : run_sum[15:0];
      total <= total + TW'((run_sum > {17'd0, elapsed}) ? elapsed : run_sum[15:0]);
      tgt   <= AW'(idx);
    end
    if (cmd.entry_mul) begin
      prod <= 32'(share_prod);
    end
    if (cmd.sum_lim) begin
      lim <= lim_prod;
    end
    if (cmd.sum_clamp && (32'(total) > 32'(lim))) begin
      total <= TW'(lim);
    end
    if (cmd.sum_mul) begin
      prod <= sum_prod;
    end
    if (cmd.out_load) begin
      res <= res_next;
    end
  end

  always_comb begin
    wdata = rdata;
    case (cmd.wsel)
      pcat_pkg::WSEL_UPDATE: begin
        wdata.user_run   = item.user_ticks - rdata.user_start;
        wdata.system_run = item.system_ticks - rdata.system_start;
        wdata.mem        = item.mem_share;
        wdata.last_seen  = cur_time;
      end
      pcat_pkg::WSEL_INSERT: begin
        wdata.pid          = item.proc_id;
        wdata.user_start   = item.user_ticks;
        wdata.system_start = item.system_ticks;
        wdata.user_run     = '0;
        wdata.system_run   = '0;
        wdata.owner_user   = item.user_id;
        wdata.owner_group  = item.group_id;
        wdata.last_seen    = cur_time;
        wdata.mem          = item.mem_share;
      end
      pcat_pkg::WSEL_EXPIRE: begin
        wdata.pid = '0;
      end
      default: begin
        wdata.user_start   = rdata.user_start + rdata.user_run;
        wdata.system_start = rdata.system_start + rdata.system_run;
        wdata.user_run     = '0;
        wdata.system_run   = '0;
        wdata.last_seen    = cur_time;
      end
    endcase
  end

  assign ram_we = cmd.ram_we;
  assign waddr  = (cmd.wsel == pcat_pkg::WSEL_UPDATE || cmd.wsel == pcat_pkg::WSEL_INSERT)
                  ? tgt : AW'(idx);

  pcat_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.ram_rd),
    .raddr (AW'(idx)),
    .rdata (rdata)
  );

  assign dvd = cmd.div_by_cpu ? quotient : prod;
  assign dvs = cmd.div_by_cpu ? 16'(ncpu) : elapsed;

  pcat_div #(.DW(32), .VW(16)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .quotient (quotient),
    .done     (div_done)
  );

  always_comb begin
    st            = '0;
    st.kind       = item.kind;
    st.pid_zero   = (item.proc_id == '0);
    st.idx_end    = (idx == used);
    st.match      = (rdata.pid == item.proc_id);
    st.free_found = free_f;
    st.full       = (used == CW'(SLOTS));
    st.live       = (rdata.pid != '0);
    st.expired    = (idle_time > 32'(expiry));
    st.div_done   = div_done;
    st.out_valid  = out_valid;
    st.out_fire   = out_valid && out_ready;
    st.out_last   = res.last;
  end
endmodule

>>> hw/rtl/pcat_ctrl.sv
module pcat_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  pcat_pkg::status_t st,
  output pcat_pkg::cmd_t    cmd
);
  typedef enum logic [23:0] {
    S_IDLE      = 24'd1 << 0,
    S_DISP      = 24'd1 << 1,
    S_SCAN_RD   = 24'd1 << 2,
    S_SCAN_CMP  = 24'd1 << 3,
    S_UPD       = 24'd1 << 4,
    S_PLACE     = 24'd1 << 5,
    S_INS       = 24'd1 << 6,
    S_ELA       = 24'd1 << 7,
    S_CALC_RD   = 24'd1 << 8,
    S_CALC_CHK  = 24'd1 << 9,
    S_CALC_MUL  = 24'd1 << 10,
    S_DIVE_GO   = 24'd1 << 11,
    S_DIVE_WAIT = 24'd1 << 12,
    S_SUM_LIM   = 24'd1 << 13,
    S_SUM_CLAMP = 24'd1 << 14,
    S_SUM_MUL   = 24'd1 << 15,
    S_DIVS_GO   = 24'd1 << 16,
    S_DIVS_WAIT = 24'd1 << 17,
    S_DIVC_GO   = 24'd1 << 18,
    S_DIVC_WAIT = 24'd1 << 19,
    S_NR_RD     = 24'd1 << 20,
    S_NR_CHK    = 24'd1 << 21,
    S_NR_END    = 24'd1 << 22,
    S_OUT       = 24'd1 << 23
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    req_ready  = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (st.kind)
          pcat_pkg::KIND_REPORT: begin
            if (st.pid_zero) begin
              cmd.out_load = 1'b1;
              cmd.osel     = pcat_pkg::OSEL_DROP;
              state_next   = S_OUT;
            end else begin
              state_next = S_SCAN_RD;
            end
          end
          pcat_pkg::KIND_SAMPLE: begin
            cmd.set_time = 1'b1;
            cmd.out_load = 1'b1;
            cmd.osel     = pcat_pkg::OSEL_DONE;
            state_next   = S_OUT;
          end
          pcat_pkg::KIND_CALC: state_next = S_ELA;
          default: state_next = S_NR_RD;
        endcase
      end
      S_SCAN_RD: begin
        if (st.idx_end) begin
          state_next = S_PLACE;
        end else begin
          cmd.ram_rd = 1'b1;
          state_next = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        cmd.scan_eval = 1'b1;
        state_next    = st.match ? S_UPD : S_SCAN_RD;
      end
      S_UPD: begin
        cmd.ram_we   = 1'b1;
        cmd.wsel     = pcat_pkg::WSEL_UPDATE;
        cmd.out_load = 1'b1;
        cmd.osel     = pcat_pkg::OSEL_UPDATE;
        state_next   = S_OUT;
      end
      S_PLACE: begin
        if (st.full && !st.free_found) begin
          cmd.out_load = 1'b1;
          cmd.osel     = pcat_pkg::OSEL_DROP;
          state_next   = S_OUT;
        end else begin
          cmd.place  = 1'b1;
          state_next = S_INS;
        end
      end
      S_INS: begin
        cmd.ram_we   = 1'b1;
        cmd.wsel     = pcat_pkg::WSEL_INSERT;
        cmd.out_load = 1'b1;
        cmd.osel     = pcat_pkg::OSEL_INSERT;
        state_next   = S_OUT;
      end
      S_ELA: begin
        cmd.ela_calc = 1'b1;
        state_next   = S_CALC_RD;
      end
      S_CALC_RD: begin
        if (st.idx_end) begin
          state_next = S_SUM_LIM;
        end else begin
          cmd.ram_rd = 1'b1;
          state_next = S_CALC_CHK;
        end
      end
      S_CALC_CHK: begin
        cmd.idx_inc = 1'b1;
        if (st.live) begin
          cmd.entry_acc = 1'b1;
          state_next    = S_CALC_MUL;
        end else begin
          state_next = S_CALC_RD;
        end
      end
      S_CALC_MUL: begin
        cmd.entry_mul = 1'b1;
        state_next    = S_DIVE_GO;
      end
      S_DIVE_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVE_WAIT;
      end
      S_DIVE_WAIT: begin
        if (st.div_done) begin
          cmd.out_load = 1'b1;
          cmd.osel     = pcat_pkg::OSEL_ENTRY;
          state_next   = S_OUT;
        end
      end
      S_SUM_LIM: begin
        cmd.sum_lim = 1'b1;
        state_next  = S_SUM_CLAMP;
      end
      S_SUM_CLAMP: begin
        cmd.sum_clamp = 1'b1;
        state_next    = S_SUM_MUL;
      end
      S_SUM_MUL: begin
        cmd.sum_mul = 1'b1;
        state_next  = S_DIVS_GO;
      end
      S_DIVS_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVS_WAIT;
      end
      S_DIVS_WAIT: begin
        if (st.div_done) begin
          state_next = S_DIVC_GO;
        end
      end
      S_DIVC_GO: begin
        cmd.div_start  = 1'b1;
        cmd.div_by_cpu = 1'b1;
        state_next     = S_DIVC_WAIT;
      end
      S_DIVC_WAIT: begin
        if (st.div_done) begin
          cmd.out_load = 1'b1;
          cmd.osel     = pcat_pkg::OSEL_SUMMARY;
          state_next   = S_OUT;
        end
      end
      S_NR_RD: begin
        if (st.idx_end) begin
          state_next = S_NR_END;
        end else begin
          cmd.ram_rd = 1'b1;
          state_next = S_NR_CHK;
        end
      end
      S_NR_CHK: begin
        cmd.idx_inc = 1'b1;
        if (st.live) begin
          cmd.ram_we = 1'b1;
          cmd.wsel   = st.expired ? pcat_pkg::WSEL_EXPIRE : pcat_pkg::WSEL_REBASE;
        end
        state_next = S_NR_RD;
      end
      S_NR_END: begin
        cmd.set_round = 1'b1;
        cmd.out_load  = 1'b1;
        cmd.osel      = pcat_pkg::OSEL_DONE;
        state_next    = S_OUT;
      end
      S_OUT: begin
        // Only the entries of a calculate request are not last.
        if (st.out_fire) begin
          state_next = st.out_last ? S_IDLE : S_CALC_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_no_pending: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !st.out_valid)
    else $error("request taken while a result is pending");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !st.out_valid)
    else $error("result register overwritten");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_DISP))
    else $error("accepted request not dispatched");
`endif
endmodule
